// File: src/scaled_histogram_with_moments_defines.svh
// Assertion macros shared by the verification code of the scaled histogram block.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef SCALED_HISTOGRAM_WITH_MOMENTS_DEFINES_SVH
`define SCALED_HISTOGRAM_WITH_MOMENTS_DEFINES_SVH

// Implication checked on every clock edge outside of reset.
`define SHM_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after any cycle with reset applied.
`define SHM_ASSERT_AFTER_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) else $error(msg);

`endif

// File: src/shm_pkg.sv
// Shared types and constants of the scaled histogram block.
// Used by every module of the block but shm_ram; depends on nothing else.
`default_nettype none

package shm_pkg;

    // Action codes carried in the command word.
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Configuration register indexes, taken from paddr[2].
    localparam logic REG_SCALE = 1'b0;
    localparam logic REG_BINS  = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [7:0]  SCALE_RESET = 8'd1;
    localparam logic [10:0] BINS_RESET  = 11'd1024;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] sample;
        logic [9:0]  bin_index;
    } t_cmd;

    typedef struct packed {
        logic [31:0] bin_value;
        logic [47:0] total_sum;
        logic [63:0] total_sum_squares;
        logic [31:0] sample_count;
        logic [31:0] overflow_count;
    } t_result;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_READ,
        OP_CLEAR,
        OP_NOP
    } t_op;

    // One classified word as it waits in the queue. The address is wide enough
    // for the largest supported store; flag is the overflow mark of an add or
    // the out-of-range mark of a read.
    typedef struct packed {
        t_op         op;
        logic [15:0] addr;
        logic        flag;
        logic [15:0] sample;
        logic [31:0] square;
    } t_entry;

endpackage

`default_nettype wire

// File: src/shm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; a read at the address being written returns the old data.
`default_nettype none

module shm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: src/shm_queue.sv
// Short first-in first-out queue of classified words between front and back.
// Depends on shm_pkg for the entry type and the queue depth.
`default_nettype none

module shm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire shm_pkg::t_entry i_entry,
    input  wire logic           i_pop,
    output shm_pkg::t_entry     o_entry,
    output logic                o_valid,
    output logic                o_full
);

    localparam int PW = $clog2(shm_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(shm_pkg::QUEUE_DEPTH + 1);

    shm_pkg::t_entry r_slot [shm_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (32'(r_wp) == shm_pkg::QUEUE_DEPTH - 1) ? '0 : r_wp + PW'(1);
        end
        if (i_pop) begin
            n_rp = (32'(r_rp) == shm_pkg::QUEUE_DEPTH - 1) ? '0 : r_rp + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_entry;
        end
    end

    assign o_entry = r_slot[r_rp];
    assign o_valid = (r_cnt != '0);
    assign o_full  = (32'(r_cnt) == shm_pkg::QUEUE_DEPTH);

endmodule

`default_nettype wire

// File: src/shm_front.sv
// Front part: configuration registers, command acceptance and classification.
// Depends on shm_pkg for the command and queue entry types.
`default_nettype none

module shm_front #(
    parameter int BINS        = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [2:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic      [31:0]     prdata,
    output logic                 pready,
    input  wire logic            i_start,
    input  wire shm_pkg::t_cmd   i_cmd,
    input  wire logic            i_busy,
    output logic                 o_push,
    output shm_pkg::t_entry      o_entry
);

    localparam int NW  = $clog2(BINS + 1);
    localparam int SW  = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
    localparam int PW  = SW + 8;
    localparam int SQW = 2 * SW;

    logic [7:0]  r_scale;
    logic [10:0] r_bin_count;

    logic [NW-1:0]  act_n;
    logic [NW-1:0]  last_bin;
    logic [SW-1:0]  smp;
    logic [PW-1:0]  prod;
    logic [SQW-1:0] sq;
    logic           ovf;
    logic           rd_zero;

    // Configuration registers; the write completes in the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= shm_pkg::SCALE_RESET;
            r_bin_count <= shm_pkg::BINS_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                shm_pkg::REG_SCALE: r_scale     <= pwdata[7:0];
                shm_pkg::REG_BINS:  r_bin_count <= pwdata[10:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            shm_pkg::REG_SCALE: prdata = {24'd0, r_scale};
            shm_pkg::REG_BINS:  prdata = {21'd0, r_bin_count};
        endcase
    end

    assign pready = 1'b1;

    // Active bin count, clamped into one to BINS.
    always_comb begin
        if (r_bin_count == '0) begin
            act_n = NW'(1);
        end else if (32'(r_bin_count) > 32'(BINS)) begin
            act_n = NW'(BINS);
        end else begin
            act_n = NW'(r_bin_count);
        end
    end

    assign last_bin = act_n - NW'(1);
    assign smp      = i_cmd.sample[SW-1:0];
    assign prod     = PW'(smp) * PW'(r_scale);
    assign sq       = SQW'(smp) * SQW'(smp);
    assign ovf      = 32'(prod) >= 32'(act_n);
    assign rd_zero  = 32'(i_cmd.bin_index) >= 32'(act_n);

    always_comb begin
        o_entry.sample = 16'(smp);
        o_entry.square = 32'(sq);
        o_entry.addr   = '0;
        o_entry.flag   = 1'b0;
        unique case (i_cmd.action)
            shm_pkg::ACT_ADD: begin
                o_entry.op   = shm_pkg::OP_ADD;
                o_entry.flag = ovf;
                o_entry.addr = ovf ? 16'(last_bin) : 16'(prod);
            end
            shm_pkg::ACT_READ: begin
                o_entry.op   = shm_pkg::OP_READ;
                o_entry.flag = rd_zero;
                o_entry.addr = 16'(i_cmd.bin_index);
            end
            shm_pkg::ACT_CLEAR: begin
                o_entry.op = shm_pkg::OP_CLEAR;
            end
            default: begin
                o_entry.op = shm_pkg::OP_NOP;
            end
        endcase
    end

    assign o_push = i_start && !i_busy;

endmodule

`default_nettype wire

// File: src/shm_back.sv
// Back part: bin store read-modify-write, running totals, clearing sweep, result word.
// Depends on shm_pkg for types and on shm_ram for the bin store.
`default_nettype none

module shm_back #(
    parameter int BINS = 1024
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire shm_pkg::t_entry i_entry,
    output logic                 o_pop,
    output logic                 o_init_busy,
    output logic                 o_done,
    output shm_pkg::t_result     o_result
);

    localparam int AW = $clog2(BINS);

    // Execute stage.
    logic            r_b_valid;
    shm_pkg::t_entry r_b;

    // Last write into the store, to cover a read issued in the same cycle.
    logic          r_fw_valid, n_fw_valid;
    logic [AW-1:0] r_fw_addr, n_fw_addr;
    logic [31:0]   r_fw_data, n_fw_data;

    // Clearing sweep.
    logic          r_sweep, n_sweep;
    logic          r_init, n_init;
    logic [AW-1:0] r_sweep_addr, n_sweep_addr;

    // Running totals.
    logic [47:0] r_sum, n_sum;
    logic [63:0] r_sq, n_sq;
    logic [31:0] r_cnt, n_cnt;
    logic [31:0] r_ovf, n_ovf;

    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic [31:0]   ram_rdata;
    logic [31:0]   cur;
    logic [31:0]   inc;
    logic [31:0]   bin_val;
    logic          b_clear;

    shm_ram #(
        .WIDTH(32),
        .DEPTH(BINS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(i_entry.addr[AW-1:0]),
        .o_rdata(ram_rdata)
    );

    assign b_clear = r_b_valid && (r_b.op == shm_pkg::OP_CLEAR);

    // The store is read when a word leaves the queue; nothing leaves during a
    // sweep or while a clear sits in the execute stage.
    assign o_pop = i_valid && !r_sweep && !b_clear;

    assign cur = (r_fw_valid && (r_fw_addr == r_b.addr[AW-1:0])) ? r_fw_data : ram_rdata;
    assign inc = (cur == '1) ? cur : cur + 32'd1;

    always_comb begin
        n_sum        = r_sum;
        n_sq         = r_sq;
        n_cnt        = r_cnt;
        n_ovf        = r_ovf;
        n_fw_valid   = r_fw_valid;
        n_fw_addr    = r_fw_addr;
        n_fw_data    = r_fw_data;
        n_sweep      = r_sweep;
        n_init       = r_init;
        n_sweep_addr = r_sweep_addr;
        bin_val      = 32'd0;
        we           = 1'b0;
        waddr        = r_sweep_addr;
        wdata        = 32'd0;

        if (r_sweep) begin
            we = 1'b1;
            n_sweep_addr = r_sweep_addr + AW'(1);
            if (r_sweep_addr == AW'(BINS - 1)) begin
                n_sweep = 1'b0;
                n_init  = 1'b0;
            end
        end

        if (r_b_valid) begin
            unique case (r_b.op)
                shm_pkg::OP_ADD: begin
                    n_sum = r_sum + 48'(r_b.sample);
                    n_sq  = r_sq + 64'(r_b.square);
                    n_cnt = (r_cnt == '1) ? r_cnt : r_cnt + 32'd1;
                    if (r_b.flag) begin
                        n_ovf = (r_ovf == '1) ? r_ovf : r_ovf + 32'd1;
                    end
                    we         = 1'b1;
                    waddr      = r_b.addr[AW-1:0];
                    wdata      = inc;
                    n_fw_valid = 1'b1;
                    n_fw_addr  = r_b.addr[AW-1:0];
                    n_fw_data  = inc;
                end
                shm_pkg::OP_READ: begin
                    bin_val = r_b.flag ? 32'd0 : cur;
                end
                shm_pkg::OP_CLEAR: begin
                    n_sum        = '0;
                    n_sq         = '0;
                    n_cnt        = '0;
                    n_ovf        = '0;
                    n_fw_valid   = 1'b0;
                    n_sweep      = 1'b1;
                    n_sweep_addr = '0;
                end
                shm_pkg::OP_NOP: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid    <= 1'b0;
            r_fw_valid   <= 1'b0;
            r_sweep      <= 1'b1;
            r_init       <= 1'b1;
            r_sweep_addr <= '0;
            r_sum        <= '0;
            r_sq         <= '0;
            r_cnt        <= '0;
            r_ovf        <= '0;
            o_done       <= 1'b0;
        end else begin
            r_b_valid    <= o_pop;
            r_fw_valid   <= n_fw_valid;
            r_sweep      <= n_sweep;
            r_init       <= n_init;
            r_sweep_addr <= n_sweep_addr;
            r_sum        <= n_sum;
            r_sq         <= n_sq;
            r_cnt        <= n_cnt;
            r_ovf        <= n_ovf;
            o_done       <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b <= i_entry;
        end
        r_fw_addr <= n_fw_addr;
        r_fw_data <= n_fw_data;
        o_result.bin_value         <= bin_val;
        o_result.total_sum         <= n_sum;
        o_result.total_sum_squares <= n_sq;
        o_result.sample_count      <= n_cnt;
        o_result.overflow_count    <= n_ovf;
    end

    assign o_init_busy = r_init;

endmodule

`default_nettype wire

// File: src/scaled_histogram_with_moments.sv
// Top level of the scaled histogram with running moments.
// Depends on shm_pkg, shm_front, shm_queue, shm_back and shm_ram.
//
// The block counts unsigned samples into a histogram held in a BINS-deep store
// of saturating 32-bit counters; a sample's bin is the sample times the scale
// register, and any bin at or past the active bin count lands in the last
// active bin and bumps the overflow count. Alongside, it keeps a wrapping sum,
// a wrapping sum of squares and a saturating sample count. A command word is
// taken at a rising edge where start is high and busy is low; every command
// gives exactly one result word on o_result, marked by o_done for a single
// cycle; the command passes the queue, the execute stage and the result
// register, and may wait in the queue during a sweep. The receiver cannot
// hold a result off, so it must sample o_result whenever o_done is high.
// While busy is low, adds, reads and no-op commands are taken at one word
// per clock: each add is a read-modify-write of one store entry, with the
// store's registered read port issued as the word leaves the queue and the
// write made in the following cycle. A clear command zeroes the totals at
// once and then sweeps the store, one entry per cycle; up to two following
// words wait in the internal queue meanwhile, after which busy stays high
// until the sweep ends. After reset the same sweep runs with busy high
// before the first command can be taken. The scale register lives at byte
// address 0 and the bin count register at byte address 4 of the configuration
// port; they should be written only while no command is outstanding.
`default_nettype none

module scaled_histogram_with_moments #(
    parameter int BINS        = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready,
    input  wire logic             start,
    output logic                  busy,
    input  wire shm_pkg::t_cmd    i_cmd,
    output logic                  o_done,
    output shm_pkg::t_result      o_result
);

    logic            push;
    shm_pkg::t_entry front_entry;
    shm_pkg::t_entry head_entry;
    logic            head_valid;
    logic            queue_full;
    logic            pop;
    logic            init_busy;

    // Commands are classified on arrival: the bin address, overflow mark and
    // square are worked out against the configuration in force at that time.
    shm_front #(
        .BINS       (BINS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .i_start(start),
        .i_cmd  (i_cmd),
        .i_busy (busy),
        .o_push (push),
        .o_entry(front_entry)
    );

    // The queue lets commands keep arriving while the back sweeps the store.
    shm_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_entry(front_entry),
        .i_pop  (pop),
        .o_entry(head_entry),
        .o_valid(head_valid),
        .o_full (queue_full)
    );

    shm_back #(
        .BINS(BINS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (head_valid),
        .i_entry    (head_entry),
        .o_pop      (pop),
        .o_init_busy(init_busy),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    // Busy covers a full queue and the store sweep that follows reset.
    assign busy = queue_full || init_busy;

endmodule

`default_nettype wire

// File: src/shm_checker.sv
// Port-level checks of the scaled histogram block, attached by a bind statement.
// Depends on shm_pkg and on the assertion macros in the defines header.
`default_nettype none

`include "scaled_histogram_with_moments_defines.svh"

module shm_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_busy,
    input wire logic             i_done,
    input wire shm_pkg::t_result i_result
);

    // No result word may come out of reset.
    `SHM_ASSERT_AFTER_RESET(a_no_done_after_reset, !i_done, "result strobe right after reset")

    // The store sweep after reset must hold commands off.
    `SHM_ASSERT_AFTER_RESET(a_busy_after_reset, i_busy, "busy low right after reset")

    // With no sample since the last clear, every total is zero.
    `SHM_ASSERT_HOLDS(a_empty_totals, i_done && i_result.sample_count == 32'd0, i_result.total_sum == 48'd0 && i_result.total_sum_squares == 64'd0 && i_result.overflow_count == 32'd0, "nonzero totals with zero sample count")

    // Overflowed samples are a subset of all samples.
    `SHM_ASSERT_HOLDS(a_ovf_le_count, i_done, i_result.overflow_count <= i_result.sample_count, "overflow count exceeds sample count")

    // A bin never counts more samples than were added in total.
    `SHM_ASSERT_HOLDS(a_bin_le_count, i_done, i_result.bin_value <= i_result.sample_count, "bin value exceeds sample count")

endmodule

bind scaled_histogram_with_moments shm_checker u_shm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_busy  (busy),
    .i_done  (o_done),
    .i_result(o_result)
);

`default_nettype wire
